// ===== design/bsm_pkg.sv =====
// Shared types and constants for the bounding sphere merge block.
package bsm_pkg;

	localparam int unsigned CoordW  = 32;
	localparam int unsigned RadiusW = 31;
	localparam int unsigned MulW    = 34;
	localparam int unsigned ProdW   = 2 * MulW;
	localparam int unsigned NumW    = 67;
	localparam int unsigned ResW    = 35;

	localparam logic MODE_SQRT = 1'b0;
	localparam logic MODE_DIV  = 1'b1;

	typedef struct packed {
		logic start;
		logic mode;
	} iter_ctl_t;

	typedef struct packed {
		logic done;
	} iter_sts_t;

endpackage

// ===== design/bsm_mul.sv =====
// Registered unsigned multiplier shared by the squaring and centre move steps.
module bsm_mul (
	input  logic                       clk,
	input  logic [bsm_pkg::MulW-1:0]   a,
	input  logic [bsm_pkg::MulW-1:0]   b,
	output logic [bsm_pkg::ProdW-1:0]  p
);
	import bsm_pkg::*;

	logic [ProdW-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= ProdW'(a) * ProdW'(b);
	end

	assign p = p_q;
endmodule

// ===== design/bsm_iter.sv =====
// Bit-serial unit computing either an integer square root or a quotient.
module bsm_iter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bsm_pkg::iter_ctl_t        ctl,
	input  logic [bsm_pkg::NumW-1:0]  num,
	input  logic [33:0]               den,
	output bsm_pkg::iter_sts_t        sts,
	output logic [bsm_pkg::ResW-1:0]  res
);
	import bsm_pkg::*;

	logic             run_q;
	logic             done_q;
	logic             mode_q;
	logic [5:0]       cnt_q;
	logic [36:0]      rem_q;
	logic [ResW-1:0]  res_q;
	logic [NumW-1:0]  src_q;
	logic [33:0]      den_q;

	logic [36:0] remn;
	logic [36:0] subtr;
	logic [37:0] diff;
	logic        ge;

	always_comb begin
		if (mode_q == MODE_SQRT) begin
			remn  = {rem_q[34:0], src_q[NumW-1 -: 2]};
			subtr = {res_q, 2'b01};
		end else begin
			remn  = {rem_q[35:0], src_q[NumW-1]};
			subtr = {3'b000, den_q};
		end
		diff = {1'b0, remn} - {1'b0, subtr};
		ge   = !diff[37];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				run_q <= 1'b1;
				cnt_q <= (ctl.mode == MODE_SQRT) ? 6'd32 : 6'd34;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mode_q <= ctl.mode;
			res_q  <= '0;
			den_q  <= den;
			if (ctl.mode == MODE_SQRT) begin
				rem_q <= '0;
				src_q <= {num[NumW-2:0], 1'b0};
			end else begin
				// The quotient is known to fit in 35 bits, so the top of the
				// numerator can go straight into the remainder.
				rem_q <= {5'b00000, num[NumW-1:ResW]};
				src_q <= {num[ResW-1:0], 32'b0};
			end
		end else if (run_q) begin
			rem_q <= ge ? diff[36:0] : remn;
			res_q <= {res_q[ResW-2:0], ge};
			if (mode_q == MODE_SQRT) begin
				src_q <= {src_q[NumW-3:0], 2'b00};
			end else begin
				src_q <= {src_q[NumW-2:0], 1'b0};
			end
		end
	end

	assign sts.done = done_q;
	assign res      = res_q;
endmodule

// ===== design/bounding_sphere_merge.sv =====
// Top level: sequencer and state of the bounding sphere accumulator.
//
// Input beats (in_x, in_y, in_z, in_radius, in_aux) arrive on in_valid and
// are taken when in_stall is low. Each beat is folded into one accumulated
// sphere, and one output beat with the updated sphere follows on out_valid,
// held until out_stall is low.
// A beat with zero radius, or one arriving at an empty accumulator, goes
// straight to the output step. Coincident, contained and containing inputs
// show their result after the square root alone. A full merge also moves
// the centre: the squared distance is built with one shared multiplier,
// the distance comes from a 33-step bit-serial square root, and each of the
// three centre coordinates needs a multiply and a 35-step serial division.
// The block holds in_stall high from acceptance until the result is placed
// in the output register, so one beat is in work at a time. The output
// register is separate, so the next beat may be taken while the previous
// result still waits on out_stall; the block only stalls at its end if the
// output register is still occupied.
// Reset empties the accumulator (all fields zero) and drops out_valid.
module bounding_sphere_merge (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [31:0]             in_x,
	input  logic signed [31:0]             in_y,
	input  logic signed [31:0]             in_z,
	input  logic [bsm_pkg::RadiusW-1:0]    in_radius,
	input  logic [bsm_pkg::RadiusW-1:0]    in_aux,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [31:0]             out_x,
	output logic signed [31:0]             out_y,
	output logic signed [31:0]             out_z,
	output logic [bsm_pkg::RadiusW-1:0]    out_radius,
	output logic [bsm_pkg::RadiusW-1:0]    out_aux
);
	import bsm_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SQM   = 4'd1;
	localparam logic [3:0] ST_SQA   = 4'd2;
	localparam logic [3:0] ST_ROOT  = 4'd3;
	localparam logic [3:0] ST_ROOTW = 4'd4;
	localparam logic [3:0] ST_DEC   = 4'd5;
	localparam logic [3:0] ST_MM    = 4'd6;
	localparam logic [3:0] ST_MW    = 4'd7;
	localparam logic [3:0] ST_DIV   = 4'd8;
	localparam logic [3:0] ST_DIVW  = 4'd9;
	localparam logic [3:0] ST_UPD   = 4'd10;
	localparam logic [3:0] ST_OUT   = 4'd11;

	logic [3:0]               state_q;
	logic [1:0]               k_q;
	logic signed [31:0]       acc_q [3];
	logic [RadiusW-1:0]       rad_q;
	logic [RadiusW-1:0]       aux_q;
	logic signed [31:0]       inc_q [3];
	logic [RadiusW-1:0]       inr_q;
	logic [32:0]              mag_q [3];
	logic [2:0]               neg_q;
	logic [65:0]              sum_q;
	logic [33:0]              n_q;
	logic [33:0]              den_q;
	logic                     out_valid_q;
	logic signed [31:0]       out_c_q [3];
	logic [RadiusW-1:0]       out_r_q;
	logic [RadiusW-1:0]       out_a_q;

	logic [MulW-1:0]   mul_a;
	logic [MulW-1:0]   mul_b;
	logic [ProdW-1:0]  prod;
	iter_ctl_t         ictl;
	iter_sts_t         ists;
	logic [NumW-1:0]   inum;
	logic [ResW-1:0]   ires;

	logic              in_acc;
	logic              out_free;
	logic [32:0]       mag_k;
	logic [32:0]       d_root;
	logic [33:0]       d_plus_r;
	logic [34:0]       d_sum3;
	logic [33:0]       nr;
	logic signed [36:0] moved;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		unique case (k_q)
			2'd0:    mag_k = mag_q[0];
			2'd1:    mag_k = mag_q[1];
			default: mag_k = mag_q[2];
		endcase
	end

	assign mul_a = {1'b0, mag_k};
	assign mul_b = (state_q == ST_SQM) ? {1'b0, mag_k} : n_q;

	assign d_root   = ires[32:0];
	assign d_plus_r = {1'b0, d_root} + {3'b000, inr_q};
	assign d_sum3   = {1'b0, d_plus_r} + {4'b0000, rad_q};
	assign nr       = d_sum3[34:1];

	always_comb begin
		ictl.start = (state_q == ST_ROOT) || (state_q == ST_DIV);
		ictl.mode  = (state_q == ST_DIV) ? MODE_DIV : MODE_SQRT;
		inum       = (state_q == ST_DIV) ? prod[NumW-1:0] : {1'b0, sum_q};
	end

	always_comb begin
		if (neg_q[k_q]) begin
			moved = 37'(signed'(acc_q[k_q])) - signed'({2'b00, ires});
		end else begin
			moved = 37'(signed'(acc_q[k_q])) + signed'({2'b00, ires});
		end
	end

	bsm_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	bsm_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ictl),
		.num    (inum),
		.den    (den_q),
		.sts    (ists),
		.res    (ires)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= 2'd0;
			out_valid_q <= 1'b0;
			acc_q[0]    <= '0;
			acc_q[1]    <= '0;
			acc_q[2]    <= '0;
			rad_q       <= '0;
			aux_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						k_q <= 2'd0;
						if (in_radius != '0 && rad_q == '0) begin
							acc_q[0] <= in_x;
							acc_q[1] <= in_y;
							acc_q[2] <= in_z;
							rad_q    <= in_radius;
							aux_q    <= in_aux;
							state_q  <= ST_OUT;
						end else begin
							if (in_aux > aux_q) begin
								aux_q <= in_aux;
							end
							state_q <= (in_radius == '0) ? ST_OUT : ST_SQM;
						end
					end
				end
				ST_SQM:  state_q <= ST_SQA;
				ST_SQA: begin
					if (k_q == 2'd2) begin
						k_q     <= 2'd0;
						state_q <= ST_ROOT;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= ST_SQM;
					end
				end
				ST_ROOT:  state_q <= ST_ROOTW;
				ST_ROOTW: begin
					if (ists.done) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					if (d_root == '0) begin
						if (inr_q > rad_q) begin
							rad_q <= inr_q;
						end
						state_q <= ST_OUT;
					end else if ({3'b000, rad_q} > d_plus_r) begin
						state_q <= ST_OUT;
					end else if ({1'b0, d_root} + {3'b000, rad_q} < {3'b000, inr_q}) begin
						acc_q[0] <= inc_q[0];
						acc_q[1] <= inc_q[1];
						acc_q[2] <= inc_q[2];
						rad_q    <= inr_q;
						state_q  <= ST_OUT;
					end else begin
						rad_q   <= (nr[33:31] != 3'b000) ? {RadiusW{1'b1}} : nr[30:0];
						state_q <= ST_MM;
					end
				end
				ST_MM:   state_q <= ST_MW;
				ST_MW:   state_q <= ST_DIV;
				ST_DIV:  state_q <= ST_DIVW;
				ST_DIVW: begin
					if (ists.done) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (moved > 37'sd2147483647) begin
						acc_q[k_q] <= 32'sh7fffffff;
					end else if (moved < -37'sd2147483648) begin
						acc_q[k_q] <= 32'sh80000000;
					end else begin
						acc_q[k_q] <= moved[31:0];
					end
					if (k_q == 2'd2) begin
						state_q <= ST_OUT;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= ST_MM;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Operand and result registers carry no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			logic signed [32:0] dx, dy, dz;
			dx = 33'(in_x) - 33'(acc_q[0]);
			dy = 33'(in_y) - 33'(acc_q[1]);
			dz = 33'(in_z) - 33'(acc_q[2]);
			inc_q[0] <= in_x;
			inc_q[1] <= in_y;
			inc_q[2] <= in_z;
			inr_q    <= in_radius;
			neg_q    <= {dz[32], dy[32], dx[32]};
			mag_q[0] <= dx[32] ? 33'(-dx) : 33'(dx);
			mag_q[1] <= dy[32] ? 33'(-dy) : 33'(dy);
			mag_q[2] <= dz[32] ? 33'(-dz) : 33'(dz);
			sum_q    <= '0;
		end
		if (state_q == ST_SQA) begin
			sum_q <= sum_q + prod[65:0];
		end
		if (state_q == ST_DEC) begin
			n_q   <= d_plus_r - {3'b000, rad_q};
			den_q <= {d_root, 1'b0};
		end
		if (state_q == ST_OUT && out_free) begin
			out_c_q[0] <= acc_q[0];
			out_c_q[1] <= acc_q[1];
			out_c_q[2] <= acc_q[2];
			out_r_q    <= rad_q;
			out_a_q    <= aux_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_x      = out_c_q[0];
	assign out_y      = out_c_q[1];
	assign out_z      = out_c_q[2];
	assign out_radius = out_r_q;
	assign out_aux    = out_a_q;

	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		ists.done |-> (state_q == ST_ROOTW || state_q == ST_DIVW))
		else $error("iterative unit finished while the sequencer was not waiting");

	a_move_needs_distance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MM) |-> (den_q != '0))
		else $error("centre move started with a zero distance");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != ST_IDLE))
		else $error("accepted beat did not start work");

	a_result_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("result presented outside the output step");
endmodule
